// File: hw/rtl/gmp_pkg.sv
// Shared types, sizes and helpers for the grid max-path score counter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package gmp_pkg;

	localparam int MAX_ROWS = 128;
	localparam int MAX_COLS = 128;

	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int DIMR_W  = ROW_W + 1;
	localparam int DIMC_W  = COL_W + 1;
	localparam int CFG_W   = 8;
	localparam int DIGIT_W = 4;
	localparam int SCORE_W = 12;
	localparam int COUNT_W = 30;

	localparam logic [COUNT_W-1:0] COUNT_MOD = COUNT_W'(1000000007);
	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

	typedef enum logic [0:0] {
		CFG_GRID_ROWS = 1'b0,
		CFG_GRID_COLS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [COUNT_W-1:0] count;
		logic               reach;
	} cell_t;

	typedef struct packed {
		logic start;
		logic blocked;
		logic use_below;
		logic use_diag;
		logic use_right;
	} nbr_sel_t;

	function automatic logic [DIMR_W-1:0] clamp_rows(input logic [CFG_W-1:0] value);
		logic [31:0] v;
		v = 32'(value);
		if (v < 32'd2) begin
			return DIMR_W'(2);
		end else if (v > 32'(MAX_ROWS)) begin
			return DIMR_W'(MAX_ROWS);
		end
		return DIMR_W'(v);
	endfunction

	function automatic logic [DIMC_W-1:0] clamp_cols(input logic [CFG_W-1:0] value);
		logic [31:0] v;
		v = 32'(value);
		if (v < 32'd2) begin
			return DIMC_W'(2);
		end else if (v > 32'(MAX_COLS)) begin
			return DIMC_W'(MAX_COLS);
		end
		return DIMC_W'(v);
	endfunction

endpackage

// File: hw/rtl/gmp_if.sv
// Valid/ready channel interfaces for grid cells in and path results out.
// Depends on gmp_pkg for field widths.
`timescale 1ns / 1ps

interface gmp_in_if import gmp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               blocked;
	logic [DIGIT_W-1:0] digit;

	modport source (output valid, output blocked, output digit, input ready);
	modport sink   (input valid, input blocked, input digit, output ready);
endinterface

interface gmp_out_if import gmp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] best_score;
	logic [COUNT_W-1:0] path_count;

	modport source (output valid, output best_score, output path_count, input ready);
	modport sink   (input valid, input best_score, input path_count, output ready);
endinterface

// File: hw/rtl/grid_max_path_score_count_top.sv
// Top level of the grid max-path score counter: position tracking, row memory,
// stage-1 evaluation and result register. Depends on gmp_pkg, gmp_if, gmp_cell_eval.
`timescale 1ns / 1ps

// Usage:
//   in_ch carries grid cells (blocked, digit) in reverse raster order: bottom row
//   first, each row right to left. The first word of a grid is the start cell.
//   out_ch carries one word (best_score, path_count) after the top-left cell;
//   all other cells produce nothing.
//   cfg_we/cfg_idx/cfg_data set grid_rows (index 0) and grid_cols (index 1),
//   clamped to 2..128; a write restarts the grid. Write only while idle.
// Throughput: one cell per cycle. The row memory read is issued as a cell is
//   taken; the merge of the three neighbors runs in the next cycle and writes
//   the memory back at a different column than the one read then.
// Result: registered from stage 1 as the top-left cell leaves it, then held on out_ch.
// Reset: positions return to the start cell and out_ch goes idle; the row
//   memory is not cleared; an entry is used only after it is written.
// Stall: the result register holds while out_ch.ready is low; cells keep
//   flowing until the next top-left cell reaches stage 1, then in_ch.ready drops.

module grid_max_path_score_count_top import gmp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	gmp_in_if.sink           in_ch,
	gmp_out_if.source        out_ch,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	cell_t below_mem [MAX_COLS];

	logic [DIMR_W-1:0] rows_q;
	logic [DIMC_W-1:0] cols_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;

	logic               in_fire, row_end, col_end;
	logic               s1_valid_q, s1_adv;
	logic               blocked_s1, row_nz_s1, col_nz_s1, last_s1;
	logic [DIGIT_W-1:0] digit_s1;
	logic [COL_W-1:0]   col_s1;
	cell_t              below_s1, diag_q, right_q, cur;
	nbr_sel_t           sel;

	logic               out_valid_q;
	logic [SCORE_W-1:0] score_q;
	logic [COUNT_W-1:0] count_q;

	assign row_end = ({1'b0, row_q} + DIMR_W'(1)) >= rows_q;
	assign col_end = ({1'b0, col_q} + DIMC_W'(1)) >= cols_q;

	assign s1_adv      = !last_s1 || !out_valid_q || out_ch.ready;
	assign in_ch.ready = !s1_valid_q || s1_adv;
	assign in_fire     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIMR_W'(MAX_ROWS);
			cols_q <= DIMC_W'(MAX_COLS);
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_GRID_ROWS: rows_q <= clamp_rows(cfg_data);
				CFG_GRID_COLS: cols_q <= clamp_cols(cfg_data);
				default: ;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (in_fire) begin
			if (row_end && col_end) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_end) begin
				row_q <= row_q + ROW_W'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// read the row below at accept; write back when the cell leaves stage 1
	always_ff @(posedge clk) begin
		if (in_fire) begin
			below_s1 <= below_mem[col_q];
		end
		if (s1_valid_q && s1_adv) begin
			below_mem[col_s1] <= cur;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			blocked_s1 <= in_ch.blocked;
			digit_s1   <= in_ch.digit;
			row_nz_s1  <= (row_q != '0);
			col_nz_s1  <= (col_q != '0);
			col_s1     <= col_q;
			last_s1    <= row_end && col_end;
		end
		if (s1_valid_q && s1_adv) begin
			right_q <= cur;
			diag_q  <= below_s1;
		end
		if (s1_valid_q && s1_adv && last_s1) begin
			score_q <= cur.score;
			count_q <= cur.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_valid_q && s1_adv && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sel.start     = !row_nz_s1 && !col_nz_s1;
	assign sel.blocked   = blocked_s1;
	assign sel.use_below = row_nz_s1;
	assign sel.use_diag  = row_nz_s1 && col_nz_s1;
	assign sel.use_right = col_nz_s1;

	gmp_cell_eval u_eval (
		.below (below_s1),
		.diag  (diag_q),
		.right (right_q),
		.sel   (sel),
		.digit (digit_s1),
		.cur   (cur)
	);

	assign out_ch.valid      = out_valid_q;
	assign out_ch.best_score = score_q;
	assign out_ch.path_count = count_q;

endmodule

// File: hw/rtl/gmp_cell_eval.sv
// Per-cell merge: best neighbor score, tied path counts mod 1e9+7, digit add.
// Depends on gmp_pkg.
`timescale 1ns / 1ps

module gmp_cell_eval import gmp_pkg::*; (
	input  cell_t              below,
	input  cell_t              diag,
	input  cell_t              right,
	input  nbr_sel_t           sel,
	input  logic [DIGIT_W-1:0] digit,
	output cell_t              cur
);

	localparam logic [31:0] MOD32  = 32'(COUNT_MOD);
	localparam logic [31:0] MOD2X  = 32'(COUNT_MOD) << 1;

	logic               b_ok, d_ok, r_ok, any_ok;
	logic [SCORE_W-1:0] b_sc, d_sc, r_sc, m_bd, best;
	logic [31:0]        sum, red;
	logic [SCORE_W:0]   sc_add;
	logic [DIGIT_W-1:0] dig_eff;

	assign b_ok   = sel.use_below && below.reach;
	assign d_ok   = sel.use_diag && diag.reach;
	assign r_ok   = sel.use_right && right.reach;
	assign any_ok = b_ok || d_ok || r_ok;

	assign b_sc = b_ok ? below.score : '0;
	assign d_sc = d_ok ? diag.score : '0;
	assign r_sc = r_ok ? right.score : '0;
	assign m_bd = (b_sc > d_sc) ? b_sc : d_sc;
	assign best = (m_bd > r_sc) ? m_bd : r_sc;

	always_comb begin
		sum = '0;
		if (b_ok && b_sc == best) sum = sum + 32'(below.count);
		if (d_ok && d_sc == best) sum = sum + 32'(diag.count);
		if (r_ok && r_sc == best) sum = sum + 32'(right.count);
		if (sum >= MOD2X) begin
			red = sum - MOD2X;
		end else if (sum >= MOD32) begin
			red = sum - MOD32;
		end else begin
			red = sum;
		end
	end

	assign dig_eff = (digit > DIGIT_MAX) ? '0 : digit;
	assign sc_add  = {1'b0, best} + (SCORE_W+1)'(dig_eff);

	always_comb begin
		if (sel.start) begin
			cur.score = '0;
			cur.count = COUNT_W'(1);
			cur.reach = 1'b1;
		end else if (sel.blocked || !any_ok) begin
			cur = '0;
		end else begin
			cur.score = sc_add[SCORE_W] ? SCORE_MAX : sc_add[SCORE_W-1:0];
			cur.count = red[COUNT_W-1:0];
			cur.reach = 1'b1;
		end
	end

endmodule

// File: hw/rtl/gmp_checker.sv
// Port-level checks for the grid max-path score counter, bound to the top level.
// Depends on gmp_pkg and grid_max_path_score_count_top.
`timescale 1ns / 1ps

module gmp_checker import gmp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [SCORE_W-1:0] best_score,
	input logic [COUNT_W-1:0] path_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> path_count < COUNT_MOD)
		else $error("path count not reduced");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(best_score) && $stable(path_count))
		else $error("result word changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked result");

endmodule

bind grid_max_path_score_count_top gmp_checker u_gmp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.best_score (out_ch.best_score),
	.path_count (out_ch.path_count)
);

// File: tb/testbench.sv
// Self-checking bench for grid_max_path_score_count_top: feeds grid cells, predicts the
// best score and path count of each grid, and checks every result word on out_ch.
// Depends on gmp_pkg, gmp_if and the RTL top.
`timescale 1ns / 1ps

module testbench;
	import gmp_pkg::*;

	typedef struct {
		logic               blocked;
		logic [DIGIT_W-1:0] digit;
	} cell_word_t;

	typedef struct {
		logic [SCORE_W-1:0] score;
		logic [COUNT_W-1:0] count;
	} path_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	gmp_in_if  cell_if ();
	gmp_out_if path_if ();

	grid_max_path_score_count_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (cell_if),
		.out_ch   (path_if),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	cell_word_t   pending_cells[$];
	path_result_t results_due[$];
	cell_word_t   next_word;
	path_result_t want;
	int           cells_pushed  = 0;
	int           cells_taken   = 0;
	int           failures      = 0;
	int           send_gap      = 0;
	int           recv_gap      = 0;
	int           hold_left     = 0;
	int           hold_requests = 0;
	int           hold_served   = 0;
	bit           steady        = 0;

	// grid tracking state
	cell_t lower_row[MAX_COLS];
	cell_t right_nb = '0;
	cell_t diag_nb  = '0;
	int    row_at   = 0;
	int    col_at   = 0;
	int    n_rows   = MAX_ROWS;
	int    n_cols   = MAX_COLS;

	function automatic void fold_neighbor(inout cell_t acc, input cell_t nb);
		logic [COUNT_W:0] s;
		if (!nb.reach) return;
		if (!acc.reach || nb.score > acc.score) begin
			acc = nb;
		end else if (nb.score == acc.score) begin
			s = acc.count + nb.count;
			if (s >= COUNT_MOD) s = s - COUNT_MOD;
			acc.count = s[COUNT_W-1:0];
		end
	endfunction

	function automatic void take_cell(input logic blk, input logic [DIGIT_W-1:0] dig);
		cell_t            cur;
		logic [SCORE_W:0] sum;
		cur = '0;
		if (row_at == 0 && col_at == 0) begin
			cur.count = 1;
			cur.reach = 1'b1;
		end else if (!blk) begin
			if (row_at > 0) fold_neighbor(cur, lower_row[col_at]);
			if (row_at > 0 && col_at > 0) fold_neighbor(cur, diag_nb);
			if (col_at > 0) fold_neighbor(cur, right_nb);
			if (cur.reach && dig <= DIGIT_MAX) begin
				sum = cur.score + dig;
				cur.score = (sum > SCORE_MAX) ? SCORE_MAX : sum[SCORE_W-1:0];
			end
		end
		if (!cur.reach) cur = '0;
		if (row_at > 0) diag_nb = lower_row[col_at];
		lower_row[col_at] = cur;
		right_nb = cur;
		if (row_at + 1 >= n_rows && col_at + 1 >= n_cols) begin
			results_due.push_back('{cur.score, cur.count});
			row_at = 0;
			col_at = 0;
			right_nb = '0;
			diag_nb = '0;
		end else if (col_at + 1 >= n_cols) begin
			col_at = 0;
			row_at = row_at + 1;
			right_nb = '0;
			diag_nb = '0;
		end else begin
			col_at = col_at + 1;
		end
	endfunction

	function automatic void apply_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		int v;
		v = (value < 2) ? 2 : int'(value);
		if (idx == CFG_GRID_ROWS) n_rows = (v > MAX_ROWS) ? MAX_ROWS : v;
		else n_cols = (v > MAX_COLS) ? MAX_COLS : v;
		row_at = 0;
		col_at = 0;
		right_nb = '0;
		diag_nb = '0;
	endfunction

	function automatic bit all_done();
		return cells_taken == cells_pushed && results_due.size() == 0;
	endfunction

	function automatic void push_cell(input logic blk, input logic [DIGIT_W-1:0] dig);
		pending_cells.push_back('{blk, dig});
		cells_pushed++;
	endfunction

	task automatic add_cells(input int count, input int pct, input bit zeros);
		logic [DIGIT_W-1:0] d;
		repeat (count) begin
			if (zeros) d = '0;
			else if ($urandom_range(15) == 0) d = DIGIT_W'($urandom_range(15, 10));
			else d = DIGIT_W'($urandom_range(9));
			push_cell($urandom_range(99) < pct, d);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value[CFG_W-1:0];
		apply_reg(idx, value[CFG_W-1:0]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mask: 0 rows only, 1 cols only, otherwise both
	task automatic set_dims(input int rows_raw, input int cols_raw, input int mask);
		do @(posedge clk); while (!all_done());
		repeat (6) @(posedge clk);
		if (mask != 1) write_reg(CFG_GRID_ROWS, rows_raw);
		if (mask != 0) write_reg(CFG_GRID_COLS, cols_raw);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

	// driver: present words from pending_cells, predict on each accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_if.valid   <= 1'b0;
			cell_if.blocked <= 1'b0;
			cell_if.digit   <= '0;
			send_gap = 0;
		end else begin
			if (cell_if.valid && cell_if.ready) begin
				take_cell(cell_if.blocked, cell_if.digit);
				cells_taken++;
			end
			if (!cell_if.valid || cell_if.ready) begin
				if (!steady && send_gap == 0 && $urandom_range(15) == 0)
					send_gap = $urandom_range(16, 1);
				if (send_gap > 0) begin
					send_gap--;
					cell_if.valid <= 1'b0;
				end else if (pending_cells.size() > 0) begin
					next_word = pending_cells.pop_front();
					cell_if.valid   <= 1'b1;
					cell_if.blocked <= next_word.blocked;
					cell_if.digit   <= next_word.digit;
				end else begin
					cell_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check result words, drive ready with random stalls and long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_if.ready <= 1'b0;
		end else begin
			if (path_if.valid && path_if.ready) begin
				if (results_due.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected word: score %0d count %0d",
							path_if.best_score, path_if.path_count);
				end else begin
					want = results_due.pop_front();
					if (want.score !== path_if.best_score || want.count !== path_if.path_count) begin
						failures++;
						if (failures <= 10)
							$display("mismatch: expected score %0d count %0d, got score %0d count %0d",
								want.score, want.count, path_if.best_score, path_if.path_count);
					end
				end
			end
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				path_if.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				path_if.ready <= 1'b0;
			end else if (!steady && $urandom_range(11) == 0) begin
				recv_gap = $urandom_range(16, 1) - 1;
				path_if.ready <= 1'b0;
			end else begin
				path_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		int rows_raw;
		int cols_raw;
		int pct;
		bit zeros;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = CFG_GRID_ROWS;
		cfg_data        = '0;
		cell_if.valid   = 1'b0;
		cell_if.blocked = 1'b0;
		cell_if.digit   = '0;
		path_if.ready   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// 2x2 grids: start, left of start, above start, top-left
		set_dims(0, 1, 2);
		push_cell(1, 15); push_cell(0, 9);  push_cell(0, 9);  push_cell(0, 0);
		push_cell(0, 0);  push_cell(0, 4);  push_cell(0, 7);  push_cell(1, 9);
		push_cell(0, 0);  push_cell(1, 9);  push_cell(1, 9);  push_cell(0, 5);
		push_cell(0, 0);  push_cell(0, 12); push_cell(0, 15); push_cell(0, 10);
		push_cell(0, 0);  push_cell(1, 3);  push_cell(0, 3);  push_cell(0, 9);
		push_cell(0, 5);  push_cell(1, 0);  push_cell(1, 0);  push_cell(1, 0);

		// hold results off while cells keep coming
		set_dims(3, 3, 2);
		hold_requests++;
		repeat (16) add_cells(n_rows * n_cols, 20, 0);

		set_dims(255, 2, 2);
		add_cells(n_rows * n_cols, 5, 0);
		set_dims(2, 128, 2);
		add_cells(n_rows * n_cols, 5, 0);
		// all-open zero grid: path counts wrap the modulus
		set_dims(20, 20, 2);
		add_cells(n_rows * n_cols, 0, 1);

		while (cells_pushed < 1750) begin
			if (cells_pushed >= 1450) steady = 1;
			rows_raw = $urandom_range(7, 2);
			cols_raw = $urandom_range(7, 2);
			case ($urandom_range(9))
				0: rows_raw = $urandom_range(1);
				1: cols_raw = $urandom_range(1);
				2: rows_raw = $urandom_range(16, 8);
				3: cols_raw = $urandom_range(16, 8);
				default: ;
			endcase
			set_dims(rows_raw, cols_raw, $urandom_range(5));
			pct = 10 * $urandom_range(5);
			zeros = ($urandom_range(4) == 0);
			repeat ($urandom_range(6, 1)) add_cells(n_rows * n_cols, pct, zeros);
			if ($urandom_range(5) == 0)
				add_cells($urandom_range(n_rows * n_cols - 1, 1), pct, zeros);
		end

		do @(posedge clk); while (!all_done());
		repeat (20) @(posedge clk);
		if (failures == 0 && results_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/gmp_pkg.sv
hw/rtl/gmp_if.sv
hw/rtl/gmp_cell_eval.sv
hw/rtl/grid_max_path_score_count_top.sv
hw/rtl/gmp_checker.sv
tb/testbench.sv
